// File: hw/rtl/ptw_pkg.sv
// shared types, sizes and codes for the page table walk engine
package ptw_pkg;

    localparam int NUM_TABLES    = 64;
    localparam int TABLE_ENTRIES = 512;
    localparam int LEVELS        = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int TBL_W     = $clog2(NUM_TABLES);
    localparam int CNT_W     = $clog2(NUM_TABLES + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ADDR_W    = TBL_W + IDX_W;
    localparam int MEM_DEPTH = NUM_TABLES * TABLE_ENTRIES;

    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int FLAG_W     = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int PN_W       = PA_W - PAGE_SHIFT;
    localparam int ENTRY_W    = 64;
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 64;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ACT_MAP    = 2'd0;
    localparam logic [1:0] ACT_UNMAP  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOMAP   = 2'd1;
    localparam logic [1:0] STAT_EXHAUST = 2'd2;

    localparam logic [0:0] REG_POOL_BASE = 1'b0;

    localparam logic [FLAG_W-1:0] LINK_FLAGS = 12'h003;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_UNMAP,
        OP_LOOKUP,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_CLEAR,
        S_LINK,
        S_FIN
    } walk_state_t;

    typedef struct packed {
        op_t                              op;
        logic [LEVELS-1:0][IDX_W-1:0]     idx;
        logic [PN_W-1:0]                  pn;
        logic [FLAG_W-1:0]                flags;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

endpackage

// File: hw/rtl/page_table_walk_map_unmap.sv
// top level of the four-level page table map, unmap and lookup engine
//
// requests enter on the in channel (action, virt_addr, phys_addr, page_flags)
// and each gives exactly one word on the out channel (status, frame_addr,
// tlb_flush), in request order; both channels move a word when valid is high
// and stall is low
// pool_base is written through the apb port at addresses 0 to 7 (paddr[3] low);
// the user must write it only while the engine is idle; the engine makes no check
// an accepted word sits in a two-entry queue; the walker takes it, then per upper
// level reads the table, checks the entry and links the next table, at the leaf
// reads and checks, then loads the result; it takes a new request only after that
// a map that allocates a table also sweeps its 512 entries clear;
// a walk that hits a missing level finishes early
// the table memory read port sets the pace: one dependent read per level
// after reset the root table is cleared with in_stall held high
// a stalled result waits in the output register; the next request is still
// accepted into the queue and walked up to the point of delivering its result
module page_table_walk_map_unmap
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [PA_W-1:0]   phys_addr,
    input  logic [FLAG_W-1:0] page_flags,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PA_W-1:0]   frame_addr,
    output logic              tlb_flush
);

    logic [PA_W-1:0] pool_base_reg, pool_base_next;
    logic            cfg_wr;
    logic            sel_pool_base;

    q_stat_t    q_stat;
    back_stat_t back_stat;
    logic       push;
    logic       pop;
    item_t      push_item;
    item_t      pop_item;

    always_comb
    begin
        pready         = 1'b1;
        sel_pool_base  = (paddr[CFG_AW-1:3] == REG_POOL_BASE);
        cfg_wr         = psel && penable && pwrite && pready;
        pool_base_next = (cfg_wr && sel_pool_base) ? pwdata[PA_W-1:0] : pool_base_reg;
        prdata         = sel_pool_base ? {{(CFG_DW-PA_W){1'b0}}, pool_base_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else
        begin
            pool_base_reg <= pool_base_next;
        end
    end

    ptw_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .virt_addr  (virt_addr),
        .phys_addr  (phys_addr),
        .page_flags (page_flags),
        .q_stat     (q_stat),
        .back_stat  (back_stat),
        .push       (push),
        .push_item  (push_item)
    );

    ptw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    ptw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pool_base  (pool_base_reg),
        .q_stat     (q_stat),
        .pop_item   (pop_item),
        .pop        (pop),
        .back_stat  (back_stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .frame_addr (frame_addr),
        .tlb_flush  (tlb_flush)
    );

endmodule

// File: hw/rtl/ptw_front.sv
// request intake: decodes the action and splits the virtual address into table indices
module ptw_front
    import ptw_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [PA_W-1:0]   phys_addr,
    input  logic [FLAG_W-1:0] page_flags,
    input  q_stat_t           q_stat,
    input  back_stat_t        back_stat,
    output logic              push,
    output item_t             push_item
);

    always_comb
    begin
        in_stall = q_stat.full || back_stat.init_busy;
        push     = in_valid && !in_stall;
    end

    always_comb
    begin
        unique case (action)
            ACT_MAP:    push_item.op = OP_MAP;
            ACT_UNMAP:  push_item.op = OP_UNMAP;
            ACT_LOOKUP: push_item.op = OP_LOOKUP;
            default:    push_item.op = OP_NONE;
        endcase
        for (int l = 0; l < LEVELS; l++)
        begin
            push_item.idx[l] = virt_addr[PAGE_SHIFT + IDX_W*(LEVELS-l) - 1 -: IDX_W];
        end
        push_item.pn    = phys_addr[PA_W-1:PAGE_SHIFT];
        push_item.flags = page_flags;
    end

endmodule

// File: hw/rtl/ptw_queue.sv
// short request queue between intake and walker
module ptw_queue
    import ptw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t q_stat
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
        q_stat.empty = (cnt_reg == '0);
        pop_item     = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ptw_back.sv
// table walker: table memory, allocation counter, clear sweeps and result register
module ptw_back
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PA_W-1:0]   pool_base,
    input  q_stat_t           q_stat,
    input  item_t             pop_item,
    output logic              pop,
    output back_stat_t        back_stat,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PA_W-1:0]   frame_addr,
    output logic              tlb_flush
);

    logic [ENTRY_W-1:0] table_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    walk_state_t state_reg, state_next;

    op_t                          op_reg, op_next;
    logic [LEVELS-1:0][IDX_W-1:0] idx_reg, idx_next;
    logic [PN_W-1:0]              pn_reg, pn_next;
    logic [FLAG_W-1:0]            flags_reg, flags_next;
    logic [LVL_W-1:0]             lvl_reg, lvl_next;
    logic [TBL_W-1:0]             tbl_reg, tbl_next;
    logic [PN_W-1:0]              link_pn_reg, link_pn_next;
    logic [TBL_W-1:0]             clr_tbl_reg, clr_tbl_next;
    logic [IDX_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]             nf_reg, nf_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic [PA_W-1:0]              res_frame_reg, res_frame_next;
    logic                         res_flush_reg, res_flush_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic [PA_W-1:0]              out_frame_reg, out_frame_next;
    logic                         out_flush_reg, out_flush_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]   rd_addr;

    logic                last_lvl;
    logic                present;
    logic                exhausted;
    logic                clr_last;
    logic                out_free;
    logic [TBL_W-1:0]    new_tbl;
    logic [PN_W-1:0]     new_pn;
    logic [PN_W:0]       link_diff;
    logic                link_ok;

    always_comb
    begin
        rd_addr   = {tbl_reg, idx_reg[lvl_reg]};
        last_lvl  = (lvl_reg == LVL_W'(LEVELS - 1));
        present   = rdata_reg[0];
        exhausted = (nf_reg >= CNT_W'(NUM_TABLES));
        clr_last  = (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
        out_free  = !out_valid_reg || !out_stall;
        new_tbl   = nf_reg[TBL_W-1:0];
        new_pn    = pool_base[PA_W-1:PAGE_SHIFT] + {{(PN_W-TBL_W){1'b0}}, new_tbl};
        link_diff = {1'b0, link_pn_reg} - {1'b0, pool_base[PA_W-1:PAGE_SHIFT]};
        link_ok   = !link_diff[PN_W]
                    && (link_diff[PN_W-1:0] < {{(PN_W-CNT_W){1'b0}}, nf_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_stat.empty)
                    state_next = (pop_item.op == OP_NONE) ? S_FIN : S_RD;
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (last_lvl)
                    state_next = S_FIN;
                else if (present)
                    state_next = S_LINK;
                else if (op_reg != OP_MAP || exhausted)
                    state_next = S_FIN;
                else
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (clr_last)
                    state_next = S_LINK;
            end
            S_LINK:
            begin
                state_next = link_ok ? S_RD : S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next         = op_reg;
        idx_next        = idx_reg;
        pn_next         = pn_reg;
        flags_next      = flags_reg;
        lvl_next        = lvl_reg;
        tbl_next        = tbl_reg;
        link_pn_next    = link_pn_reg;
        clr_tbl_next    = clr_tbl_reg;
        clr_cnt_next    = clr_cnt_reg;
        nf_next         = nf_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_flush_next  = res_flush_reg;
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_flush_next  = out_flush_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr;
        mem_wdata       = '0;
        pop             = 1'b0;
        back_stat.init_busy = (state_reg == S_INIT);

        unique case (state_reg)
            S_INIT:
            begin
                mem_we       = 1'b1;
                mem_waddr    = {clr_tbl_reg, clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop             = 1'b1;
                    op_next         = pop_item.op;
                    idx_next        = pop_item.idx;
                    pn_next         = pop_item.pn;
                    flags_next      = pop_item.flags;
                    lvl_next        = '0;
                    tbl_next        = '0;
                    res_status_next = STAT_DONE;
                    res_frame_next  = '0;
                    res_flush_next  = 1'b0;
                end
            end
            S_RD:
            begin
            end
            S_CHK:
            begin
                priority if (last_lvl)
                begin
                    unique case (op_reg)
                        OP_MAP:
                        begin
                            mem_we         = 1'b1;
                            mem_wdata      = {{(ENTRY_W-PA_W){1'b0}}, pn_reg,
                                              flags_reg[FLAG_W-1:1], 1'b1};
                            res_flush_next = 1'b1;
                        end
                        OP_UNMAP:
                        begin
                            mem_we         = 1'b1;
                            res_flush_next = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            res_frame_next = {rdata_reg[PA_W-1:PAGE_SHIFT],
                                              {PAGE_SHIFT{1'b0}}};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (present)
                begin
                    link_pn_next = rdata_reg[PA_W-1:PAGE_SHIFT];
                end
                else if (op_reg != OP_MAP)
                begin
                    res_status_next = STAT_NOMAP;
                end
                else if (exhausted)
                begin
                    res_status_next = STAT_EXHAUST;
                end
                else
                begin
                    // link a fresh table, then sweep it clear
                    mem_we       = 1'b1;
                    mem_wdata    = {{(ENTRY_W-PA_W){1'b0}}, new_pn, LINK_FLAGS};
                    link_pn_next = new_pn;
                    clr_tbl_next = new_tbl;
                    clr_cnt_next = '0;
                    nf_next      = nf_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = {clr_tbl_reg, clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_LINK:
            begin
                if (link_ok)
                begin
                    tbl_next = link_diff[TBL_W-1:0];
                    lvl_next = lvl_reg + 1'b1;
                end
                else
                begin
                    res_status_next = STAT_NOMAP;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_frame_next  = res_frame_reg;
                    out_flush_next  = res_flush_reg;
                end
            end
            default:
            begin
            end
        endcase

        out_valid  = out_valid_reg;
        status     = out_status_reg;
        frame_addr = out_frame_reg;
        tlb_flush  = out_flush_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_tbl_reg   <= '0;
            clr_cnt_reg   <= '0;
            nf_reg        <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_tbl_reg   <= clr_tbl_next;
            clr_cnt_reg   <= clr_cnt_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        pn_reg         <= pn_next;
        flags_reg      <= flags_next;
        lvl_reg        <= lvl_next;
        tbl_reg        <= tbl_next;
        link_pn_reg    <= link_pn_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_flush_reg  <= res_flush_next;
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_flush_reg  <= out_flush_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[rd_addr];
    end

endmodule
